>>> design/hsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hsp_pkg;

  localparam int COMPONENT_SLOTS_DEF = 256;
  localparam int QUANT_ENTRIES       = 64;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QPTR_W              = $clog2(QUEUE_DEPTH);

  localparam logic [7:0]  SAMPLE_PRECISION = 8'd8;
  localparam logic [15:0] FRAME_HDR_LEN    = 16'd6;
  localparam logic [9:0]  SCAN_HDR_LEN     = 10'd4;
  localparam logic [3:0]  MAX_TABLE_ID     = 4'd4;
  localparam logic [3:0]  MAX_FACTOR       = 4'd4;

  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_QUANT = 2'd1,
    OP_SCAN  = 2'd2,
    OP_BAD   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    RK_ACCEPT  = 3'd0,
    RK_REJECT  = 3'd1,
    RK_QUANT   = 3'd2,
    RK_FRAME_C = 3'd3,
    RK_SCAN_C  = 3'd4
  } result_kind_e;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [1:0]  table_id;
    logic [1:0]  ac_table_id;
    logic [7:0]  entry_index;
    logic [7:0]  entry_value;
    logic [2:0]  h_factor;
    logic [2:0]  v_factor;
    logic [15:0] image_height;
    logic [15:0] image_width;
    logic [7:0]  component_count;
    logic [2:0]  max_h_factor;
    logic [2:0]  max_v_factor;
  } res_t;

  // Up to two words handed from the parser to the result queue per item
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

endpackage
`default_nettype wire

>>> design/hsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

>>> design/hsp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hsp_front #(
  parameter int COMPONENT_SLOTS = hsp_pkg::COMPONENT_SLOTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          acc_i,
  input  wire logic [1:0]    opcode_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic [15:0]   segment_length_i,
  input  wire logic          last_byte_i,
  output hsp_pkg::push_t     push_o
);
  import hsp_pkg::*;

  localparam int AW = $clog2(COMPONENT_SLOTS);
  localparam logic [8:0] SLOTS9 = 9'(COMPONENT_SLOTS);

  logic [15:0] pos_q, pos_d;
  logic [1:0]  mod3_q, mod3_d;
  logic [7:0]  div3_q, div3_d;
  logic [6:0]  mod65_q, mod65_d;
  logic        fail_q, fail_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  hid_q, hid_d;
  logic [7:0]  hs_q, hs_d;
  logic [1:0]  qsel_q, qsel_d;
  logic [15:0] fh_q, fh_d;
  logic [15:0] fw_q, fw_d;
  logic [2:0]  mh_q, mh_d;
  logic [2:0]  mv_q, mv_d;

  // component table lookup tracking
  logic [COMPONENT_SLOTS-1:0] vld_q;
  logic        rvld_q, oor_q, ovr_q;
  logic [7:0]  ovr_data_q, rdata, entry;
  logic        rd_en, wr_en;
  logic [7:0]  wr_data;

  logic [7:0]  b;
  logic [15:0] len;
  logic [9:0]  len_frame, len_scan;
  logic [7:0]  s65;
  logic        len65_ok;
  logic [3:0]  hf, vf;
  logic [2:0]  eh, ev;
  res_t        comp_r, fin_r;
  logic        comp_v;

  assign b   = data_byte_i;
  assign len = segment_length_i;
  assign len_frame = {2'b0, b} + {1'b0, b, 1'b0} + 10'(FRAME_HDR_LEN);
  assign len_scan  = {1'b0, b, 1'b0} + SCAN_HDR_LEN;
  // 64 = -1 and 4096 = 1 modulo 65
  assign s65 = 8'(len[5:0]) + 8'(len[15:12]) + 8'(QUANT_ENTRIES + 1) - 8'(len[11:6]);
  assign len65_ok = (s65 == 8'(QUANT_ENTRIES + 1)) || (s65 == 8'(2 * (QUANT_ENTRIES + 1)));
  assign hf = hs_q[7:4];
  assign vf = hs_q[3:0];
  assign entry = oor_q ? 8'h00 : (ovr_q ? ovr_data_q : (rvld_q ? rdata : 8'h00));
  assign eh = entry[6:4];
  assign ev = entry[2:0];

  always_comb begin
    pos_d = pos_q; mod3_d = mod3_q; div3_d = div3_q; mod65_d = mod65_q;
    fail_d = fail_q; total_d = total_q; hid_d = hid_q; hs_d = hs_q;
    qsel_d = qsel_q; fh_d = fh_q; fw_d = fw_q; mh_d = mh_q; mv_d = mv_q;
    rd_en = 1'b0; wr_en = 1'b0;
    wr_data = {1'b0, hf[2:0], 1'b0, vf[2:0]};
    comp_r = '0; comp_v = 1'b0; fin_r = '0;
    push_o = '0;
    if (acc_i) begin
      if (!fail_q) begin
        if (pos_q >= len) begin
          fail_d = 1'b1;
        end else begin
          case (opcode_e'(opcode_i))
            OP_FRAME: begin
              if (pos_q == 16'd0) begin
                if (len < FRAME_HDR_LEN || b != SAMPLE_PRECISION) fail_d = 1'b1;
              end else if (pos_q == 16'd1) begin
                fh_d = {b, 8'h00};
              end else if (pos_q == 16'd2) begin
                fh_d = fh_q | {8'h00, b};
                if (fh_d == 16'd0) fail_d = 1'b1;
              end else if (pos_q == 16'd3) begin
                fw_d = {b, 8'h00};
              end else if (pos_q == 16'd4) begin
                fw_d = fw_q | {8'h00, b};
                if (fw_d == 16'd0) fail_d = 1'b1;
              end else if (pos_q == 16'd5) begin
                total_d = b;
                if (len != {6'b0, len_frame}) fail_d = 1'b1;
              end else begin
                case (mod3_q)
                  2'd0: begin
                    hid_d = b;
                    rd_en = 1'b1;
                  end
                  2'd1: hs_d = b;
                  default: begin
                    if (hf == 4'd0 || hf > MAX_FACTOR || vf == 4'd0 || vf > MAX_FACTOR
                        || b >= 8'(MAX_TABLE_ID)) begin
                      fail_d = 1'b1;
                    end else begin
                      wr_en = ({1'b0, hid_q} < SLOTS9);
                      comp_v = 1'b1;
                      comp_r.result_kind = RK_FRAME_C;
                      comp_r.table_id    = b[1:0];
                      comp_r.entry_index = div3_q - 8'd2;
                      comp_r.entry_value = hid_q;
                      comp_r.h_factor    = hf[2:0];
                      comp_r.v_factor    = vf[2:0];
                    end
                  end
                endcase
              end
            end
            OP_QUANT: begin
              if (pos_q == 16'd0 && (len == 16'd0 || !len65_ok)) begin
                fail_d = 1'b1;
              end else if (mod65_q == 7'd0) begin
                if (b[7:4] != 4'd0 || b[3:0] >= MAX_TABLE_ID) fail_d = 1'b1;
                else qsel_d = b[1:0];
              end else begin
                comp_v = 1'b1;
                comp_r.result_kind = RK_QUANT;
                comp_r.table_id    = qsel_q;
                comp_r.entry_index = {1'b0, mod65_q - 7'd1};
                comp_r.entry_value = b;
              end
            end
            OP_SCAN: begin
              if (pos_q == 16'd0) begin
                total_d = b;
                mh_d = 3'd0;
                mv_d = 3'd0;
                if (len != {6'b0, len_scan}) fail_d = 1'b1;
              end else if (pos_q <= {7'b0, total_q, 1'b0}) begin
                if (pos_q[0]) begin
                  hid_d = b;
                  rd_en = 1'b1;
                end else if (b[7:4] >= MAX_TABLE_ID || b[3:0] >= MAX_TABLE_ID) begin
                  fail_d = 1'b1;
                end else begin
                  if (eh > mh_q) mh_d = eh;
                  if (ev > mv_q) mv_d = ev;
                  comp_v = 1'b1;
                  comp_r.result_kind  = RK_SCAN_C;
                  comp_r.table_id     = b[5:4];
                  comp_r.ac_table_id  = b[1:0];
                  comp_r.entry_index  = pos_q[8:1] - 8'd1;
                  comp_r.entry_value  = hid_q;
                  comp_r.h_factor     = eh;
                  comp_r.v_factor     = ev;
                  comp_r.max_h_factor = mh_d;
                  comp_r.max_v_factor = mv_d;
                end
              end
            end
            default: fail_d = 1'b1;
          endcase
        end
      end

      if (last_byte_i) begin
        if (!fail_d && ({1'b0, pos_q} + 17'd1 == {1'b0, len})) begin
          fin_r.result_kind = RK_ACCEPT;
          if (opcode_i == OP_FRAME) begin
            fin_r.image_height    = fh_d;
            fin_r.image_width     = fw_d;
            fin_r.component_count = total_d;
          end else if (opcode_i == OP_SCAN) begin
            fin_r.component_count = total_d;
            fin_r.max_h_factor    = mh_d;
            fin_r.max_v_factor    = mv_d;
          end
        end else begin
          fin_r.result_kind = RK_REJECT;
        end
        pos_d = '0; mod3_d = '0; div3_d = '0; mod65_d = '0;
        fail_d = 1'b0;
      end else if (pos_q != 16'hFFFF) begin
        pos_d = pos_q + 16'd1;
        if (mod3_q == 2'd2) begin
          mod3_d = 2'd0;
          div3_d = div3_q + 8'd1;
        end else begin
          mod3_d = mod3_q + 2'd1;
        end
        mod65_d = (mod65_q == 7'(QUANT_ENTRIES)) ? 7'd0 : mod65_q + 7'd1;
      end

      // pack: component word first, then the end-of-segment verdict
      if (comp_v) begin
        push_o.res0  = comp_r;
        push_o.res1  = fin_r;
        push_o.count = last_byte_i ? 2'd2 : 2'd1;
      end else begin
        push_o.res0  = fin_r;
        push_o.count = last_byte_i ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; mod3_q <= '0; div3_q <= '0; mod65_q <= '0;
      fail_q <= 1'b0; total_q <= '0; hid_q <= '0; hs_q <= '0; qsel_q <= '0;
      fh_q <= '0; fw_q <= '0; mh_q <= '0; mv_q <= '0;
      vld_q <= '0; rvld_q <= 1'b0; oor_q <= 1'b0; ovr_q <= 1'b0; ovr_data_q <= '0;
    end else begin
      pos_q <= pos_d; mod3_q <= mod3_d; div3_q <= div3_d; mod65_q <= mod65_d;
      fail_q <= fail_d; total_q <= total_d; hid_q <= hid_d; hs_q <= hs_d;
      qsel_q <= qsel_d; fh_q <= fh_d; fw_q <= fw_d; mh_q <= mh_d; mv_q <= mv_d;
      if (rd_en) begin
        rvld_q <= vld_q[b[AW-1:0]];
        oor_q  <= ({1'b0, b} >= SLOTS9);
        ovr_q  <= 1'b0;
      end
      if (wr_en) begin
        vld_q[hid_q[AW-1:0]] <= 1'b1;
        ovr_q      <= 1'b1;
        ovr_data_q <= wr_data;
      end
    end
  end

  hsp_ram #(
    .WIDTH(8),
    .DEPTH(COMPONENT_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (hid_q[AW-1:0]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (b[AW-1:0]),
    .rdata_o (rdata)
  );
endmodule
`default_nettype wire

>>> design/hsp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hsp_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hsp_pkg::push_t push_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output hsp_pkg::res_t      out_o
);
  import hsp_pkg::*;

  res_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;
  logic              ov_q;
  res_t              out_q;
  logic              load;

  // room for two words whatever the drain side does
  assign space_o     = (cnt_q <= (QPTR_W + 1)'(QUEUE_DEPTH - 2));
  assign load        = (cnt_q != '0) && (!ov_q || out_ready_i);
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) q_mem[wp_q] <= push_i.res0;
    if (push_i.count == 2'd2) q_mem[wp_q + QPTR_W'(1)] <= push_i.res1;
    if (load) out_q <= q_mem[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      wp_q  <= wp_q + QPTR_W'(push_i.count);
      rp_q  <= rp_q + QPTR_W'(load);
      cnt_q <= cnt_q + (QPTR_W + 1)'(push_i.count) - (QPTR_W + 1)'(load);
      if (load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> design/jpeg_header_segment_parser.sv
// Baseline JPEG header segment parser. Feed the payload of one frame-start,
// quantization-table or scan-start segment a word at a time, each word with
// its segment kind, the declared length and a last mark. The block emits one
// word per quantization entry, frame component and scan component, then an
// accept or reject word on the last byte; after the first error the rest of
// the segment is dropped. The parser decodes each input word in the cycle it
// is accepted and pushes up to two result words into a four-entry queue,
// which drains one word a cycle into the output register while out_ready_i
// is high or the register is empty. Input is held off only while the queue
// has fewer than two free slots. Component sampling factors live in a table
// of COMPONENT_SLOTS entries with a registered read, issued as soon as the
// component id byte arrives; valid bits make the table read as zero from
// reset, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module jpeg_header_segment_parser #(
  parameter int COMPONENT_SLOTS = hsp_pkg::COMPONENT_SLOTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] segment_length_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       result_kind_o,
  output logic [1:0]       table_id_o,
  output logic [1:0]       ac_table_id_o,
  output logic [7:0]       entry_index_o,
  output logic [7:0]       entry_value_o,
  output logic [2:0]       h_factor_o,
  output logic [2:0]       v_factor_o,
  output logic [15:0]      image_height_o,
  output logic [15:0]      image_width_o,
  output logic [7:0]       component_count_o,
  output logic [2:0]       max_h_factor_o,
  output logic [2:0]       max_v_factor_o
);
  import hsp_pkg::*;

  push_t push;
  res_t  res;
  logic  space;
  logic  acc;

  // take a word whenever the queue can absorb its worst case of two results
  assign in_ready_o = space;
  assign acc        = in_valid_i & space;

  hsp_front #(
    .COMPONENT_SLOTS(COMPONENT_SLOTS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .acc_i            (acc),
    .opcode_i         (opcode_i),
    .data_byte_i      (data_byte_i),
    .segment_length_i (segment_length_i),
    .last_byte_i      (last_byte_i),
    .push_o           (push)
  );

  hsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  // spread the result word onto its field ports
  assign result_kind_o     = res.result_kind;
  assign table_id_o        = res.table_id;
  assign ac_table_id_o     = res.ac_table_id;
  assign entry_index_o     = res.entry_index;
  assign entry_value_o     = res.entry_value;
  assign h_factor_o        = res.h_factor;
  assign v_factor_o        = res.v_factor;
  assign image_height_o    = res.image_height;
  assign image_width_o     = res.image_width;
  assign component_count_o = res.component_count;
  assign max_h_factor_o    = res.max_h_factor;
  assign max_v_factor_o    = res.max_v_factor;
endmodule
`default_nettype wire

>>> design/hsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module hsp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  result_kind_o,
  input wire logic [7:0]  entry_index_o,
  input wire logic [7:0]  entry_value_o,
  input wire logic [2:0]  h_factor_o,
  input wire logic [2:0]  v_factor_o
);
  import hsp_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(entry_value_o))
    else $error("result word changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_kind_o <= RK_SCAN_C)
    else $error("result kind out of range");

  a_qidx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_QUANT |-> entry_index_o < 8'(QUANT_ENTRIES))
    else $error("quant entry index out of range");

  a_fact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_FRAME_C |->
      h_factor_o != 3'd0 && h_factor_o <= 3'd4 && v_factor_o != 3'd0 && v_factor_o <= 3'd4)
    else $error("frame component sampling factor out of range");
endmodule

bind jpeg_header_segment_parser hsp_checker u_hsp_checker (.*);
`default_nettype wire
